/* rtl/uci_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uci_pkg
// Shared types and constants of the UTF-8 codepoint range indexer: command
// and register codes, sequencer states, walk phases and the control and
// status bundles between the sequencer and the walk datapath.
// ----------------------------------------------------------------------------
package uci_pkg;

    // default depth of the byte store
    localparam int unsigned UCI_MAX_BYTES = 4096;

    // fixed field widths
    localparam int unsigned QW     = 16;  // signed query positions
    localparam int unsigned OW     = 13;  // result fields
    localparam int unsigned ADW    = 12;  // load address
    localparam int unsigned BW     = 8;   // string byte
    localparam int unsigned CMDW   = 2;
    localparam int unsigned CFG_IW = 1;
    localparam int unsigned CFG_DW = 13;

    // item commands
    localparam logic [CMDW-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMDW-1:0] CMD_RANGE = 2'd1;
    localparam logic [CMDW-1:0] CMD_COUNT = 2'd2;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_TEXT_LENGTH = 1'd0;
    localparam logic [CFG_IW-1:0] REG_ASCII_ONLY  = 1'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_STEP,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } t_state;

    // which walk of an item is running
    typedef enum logic [1:0] {
        PH_BEGIN,
        PH_END,
        PH_COUNT
    } t_phase;

    // sequencer to datapath
    typedef struct packed {
        t_phase phase;
        logic   start;       // load walk origin, or direct ascii result
        logic   step;        // take one codepoint step
        logic   rd;          // fetch byte at walk position
        logic   adv;         // move over one continuation byte
        logic   hold_begin;  // keep begin offset while end walk runs
        logic   save;        // store walk end as cursor
    } t_walk_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic more;      // another codepoint step is due
        logic in_range;  // walk position still inside the string
        logic trail;     // fetched byte is a continuation byte
    } t_walk_sts;

endpackage
`default_nettype wire

/* rtl/uci_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uci_store
// Byte store holding the string: one write port for load items and one
// read port with registered read data for the walk.
// ----------------------------------------------------------------------------
module uci_store
    import uci_pkg::*;
#(
    parameter  int unsigned MAX_BYTES = UCI_MAX_BYTES,
    localparam int unsigned AW        = $clog2(MAX_BYTES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [BW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [BW-1:0] o_rdata
);

    logic [BW-1:0] r_mem [MAX_BYTES];
    logic [BW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/uci_walk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uci_walk
// Walk datapath: byte position stepped by one shared increment/decrement unit,
// codepoint counter, origin selection from the forward and backward cursors,
// direct ascii mapping and the result fields.
// ----------------------------------------------------------------------------
module uci_walk
    import uci_pkg::*;
#(
    parameter  int unsigned MAX_BYTES = UCI_MAX_BYTES,
    localparam int unsigned CW        = $clog2(MAX_BYTES + 1),
    localparam int unsigned AW        = $clog2(MAX_BYTES)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_walk_ctl            i_ctl,
    input  wire logic                 i_clr,
    input  wire logic                 i_ascii,
    input  wire logic [CW-1:0]        i_len,
    input  wire logic signed [QW-1:0] i_from,
    input  wire logic signed [QW-1:0] i_to,
    input  wire logic [BW-1:0]        i_rdata,
    output t_walk_sts                 o_sts,
    output logic [AW-1:0]             o_raddr,
    output logic [OW-1:0]             o_begin,
    output logic [OW-1:0]             o_end,
    output logic [OW-1:0]             o_count
);

    localparam int unsigned PW = QW + 1;
    localparam int unsigned KW = (CW > PW) ? CW : PW;

    // walk registers
    logic [CW-1:0] r_b;
    logic [CW-1:0] r_c;
    logic [PW-1:0] r_pos;
    logic          r_fwd;
    logic          r_unb;
    logic [CW-1:0] r_begin;

    // cursors
    logic          r_fwd_vld;
    logic [CW-1:0] r_fwd_c;
    logic [CW-1:0] r_fwd_b;
    logic          r_bwd_vld;
    logic [CW-1:0] r_bwd_c;
    logic [CW-1:0] r_bwd_b;

    logic [PW-1:0] w_from_x;
    logic [PW-1:0] w_to_x;
    logic [PW-1:0] w_st_pos;
    logic          w_st_fwd;
    logic          w_st_unb;
    logic [KW-1:0] w_pos_k;
    logic [KW-1:0] w_len_k;
    logic [KW-1:0] w_asc_fwd;
    logic [KW-1:0] w_asc_bwd;
    logic          w_fwd_hit;
    logic          w_bwd_hit;
    logic [CW-1:0] w_st_b;
    logic [CW-1:0] w_st_c;
    logic [CW-1:0] w_b_step;
    logic          w_in_range;
    logic [CW+OW-1:0] w_b_ext;
    logic [CW+OW-1:0] w_c_ext;
    logic [CW+OW-1:0] w_beg_ext;

    assign w_from_x = {i_from[QW-1], i_from};
    assign w_to_x   = {i_to[QW-1], i_to};

    // walk direction and target count for the phase
    always_comb begin
        w_st_fwd = 1'b1;
        w_st_unb = 1'b0;
        w_st_pos = '0;
        unique case (i_ctl.phase)
            PH_BEGIN: begin
                if (!i_from[QW-1]) begin
                    w_st_pos = (i_from == '0) ? '0 : w_from_x - PW'(1);
                end else begin
                    w_st_fwd = 1'b0;
                    w_st_pos = PW'(0) - w_from_x;
                end
            end
            PH_END: begin
                if (!i_to[QW-1]) begin
                    w_st_pos = w_to_x;
                end else begin
                    w_st_fwd = 1'b0;
                    w_st_pos = ~w_to_x;
                end
            end
            PH_COUNT: begin
                w_st_unb = 1'b1;
            end
            default: begin
                w_st_unb = 1'b0;
            end
        endcase
    end

    // ascii mode maps positions straight to bytes
    assign w_pos_k   = KW'(w_st_pos);
    assign w_len_k   = KW'(i_len);
    assign w_asc_fwd = (w_pos_k < w_len_k) ? w_pos_k : w_len_k;
    assign w_asc_bwd = (w_len_k > w_pos_k) ? (w_len_k - w_pos_k) : '0;

    // resume from a cursor that lies at or before the target
    assign w_fwd_hit = r_fwd_vld && !w_st_unb && (w_pos_k >= KW'(r_fwd_c));
    assign w_bwd_hit = r_bwd_vld && (w_pos_k >= KW'(r_bwd_c));

    // walk origin
    always_comb begin
        w_st_b = '0;
        w_st_c = '0;
        if (i_ascii) begin
            w_st_c = i_len;
            w_st_b = w_st_fwd ? w_asc_fwd[CW-1:0] : w_asc_bwd[CW-1:0];
        end else if (w_st_fwd) begin
            if (w_fwd_hit) begin
                w_st_b = r_fwd_b;
                w_st_c = r_fwd_c;
            end
        end else if (w_bwd_hit) begin
            w_st_b = r_bwd_b;
            w_st_c = r_bwd_c;
        end else begin
            w_st_b = i_len;
        end
    end

    // shared position step unit and limit compares
    assign w_b_step   = r_fwd ? (r_b + CW'(1)) : (r_b - CW'(1));
    assign w_in_range = r_fwd ? (r_b < i_len) : (r_b != '0);

    assign o_sts.in_range = w_in_range;
    assign o_sts.more     = w_in_range && (r_unb || (KW'(r_c) < KW'(r_pos)));
    assign o_sts.trail    = (i_rdata[BW-1:BW-2] == 2'b10);

    assign o_raddr = r_b[AW-1:0];

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_b   <= w_st_b;
            r_c   <= w_st_c;
            r_pos <= w_st_pos;
            r_fwd <= w_st_fwd;
            r_unb <= w_st_unb;
        end else if (i_ctl.step) begin
            r_b <= w_b_step;
            r_c <= r_c + CW'(1);
        end else if (i_ctl.adv) begin
            r_b <= w_b_step;
        end
        if (i_ctl.hold_begin) begin
            r_begin <= r_b;
        end
    end

    // cursor validity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_vld <= 1'b0;
            r_bwd_vld <= 1'b0;
        end else if (i_clr) begin
            r_fwd_vld <= 1'b0;
            r_bwd_vld <= 1'b0;
        end else if (i_ctl.save) begin
            if (r_fwd) begin
                r_fwd_vld <= 1'b1;
            end else begin
                r_bwd_vld <= 1'b1;
            end
        end
    end

    // cursor positions
    always_ff @(posedge i_clk) begin
        if (i_ctl.save) begin
            if (r_fwd) begin
                r_fwd_c <= r_c;
                r_fwd_b <= r_b;
            end else begin
                r_bwd_c <= r_c;
                r_bwd_b <= r_b;
            end
        end
    end

    // result fields
    assign w_b_ext   = (CW + OW)'(r_b);
    assign w_c_ext   = (CW + OW)'(r_c);
    assign w_beg_ext = (CW + OW)'(r_begin);

    always_comb begin
        if (i_ctl.phase == PH_COUNT) begin
            o_begin = '0;
            o_end   = '0;
            o_count = w_c_ext[OW-1:0];
        end else begin
            o_begin = w_beg_ext[OW-1:0];
            o_end   = w_b_ext[OW-1:0];
            o_count = '0;
        end
    end

    // a valid forward cursor never lies past the string end
    a_fwd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_vld |-> (r_fwd_b <= i_len))
        else $error("forward cursor beyond string end");

    // a codepoint step counts exactly one codepoint
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.step |=> (r_c == $past(r_c) + CW'(1)))
        else $error("codepoint counter out of step");

endmodule
`default_nettype wire

/* rtl/uci_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uci_ctrl
// Sequencer: takes items, runs the begin and end walks of a range query or
// the counting walk, byte by byte through the store, and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module uci_ctrl
    import uci_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [CMDW-1:0] i_cmd,
    input  wire logic            i_ascii,
    input  wire logic            i_out_busy,
    input  wire t_walk_sts       i_sts,
    output logic                 o_in_stall,
    output t_walk_ctl            o_ctl,
    output logic                 o_out_load
);

    t_state r_state;
    t_state n_state;
    t_phase r_phase;
    t_phase n_phase;
    logic   w_accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_BEGIN;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        CMD_RANGE: begin
                            n_state = ST_START;
                            n_phase = PH_BEGIN;
                        end
                        CMD_COUNT: begin
                            n_state = ST_START;
                            n_phase = PH_COUNT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_START: begin
                n_state = i_ascii ? ST_FINISH : ST_STEP;
            end
            ST_STEP: begin
                n_state = i_sts.more ? ST_READ : ST_FINISH;
            end
            ST_READ: begin
                n_state = i_sts.in_range ? ST_CHECK : ST_STEP;
            end
            ST_CHECK: begin
                n_state = i_sts.trail ? ST_READ : ST_STEP;
            end
            ST_FINISH: begin
                if (r_phase == PH_BEGIN) begin
                    n_state = ST_START;
                    n_phase = PH_END;
                end else if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb begin
        o_ctl            = '0;
        o_ctl.phase      = r_phase;
        o_out_load       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_out_load = 1'b0;
            end
            ST_START: begin
                o_ctl.start = 1'b1;
            end
            ST_STEP: begin
                o_ctl.step = i_sts.more;
            end
            ST_READ: begin
                o_ctl.rd = i_sts.in_range;
            end
            ST_CHECK: begin
                o_ctl.adv = i_sts.trail;
            end
            ST_FINISH: begin
                o_ctl.save       = !i_ascii && (r_phase != PH_COUNT);
                o_ctl.hold_begin = (r_phase == PH_BEGIN);
                o_out_load       = (r_phase != PH_BEGIN) && !i_out_busy;
            end
            default: begin
                o_out_load = 1'b0;
            end
        endcase
    end

    // a result is never loaded over one still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |-> !i_out_busy)
        else $error("result overwritten");

    // a fetch is always followed by its check
    a_read_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && i_sts.in_range) |=> (r_state == ST_CHECK))
        else $error("fetched byte not checked");

    // a query item starts a walk in the next cycle
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_RANGE || i_cmd == CMD_COUNT))
        |=> (r_state == ST_START))
        else $error("query item not started");

endmodule
`default_nettype wire

/* rtl/utf8_codepoint_range_indexer_core.sv */
`default_nettype none
// Load item: taken while idle, the store is written at the edge that takes it.
// Query item: each walk passes start, a step per codepoint, read and check per byte
// fetched from the single store read port, a further step when a step runs into a
// string end, and finish; two walks per range query, ascii walks go start to finish.
// The result then enters the output register, the next item is taken after.
// Reset clears control, registers and cursors; the byte store is not cleared.
// ----------------------------------------------------------------------------
// utf8_codepoint_range_indexer_core
// Holds a UTF-8 string and turns signed codepoint ranges into byte ranges
// and counts codepoints, walking the store one byte per step with cursors
// that let later walks resume.
// ----------------------------------------------------------------------------
module utf8_codepoint_range_indexer_core
    import uci_pkg::*;
#(
    parameter int unsigned MAX_BYTES = UCI_MAX_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IW-1:0]    i_cfg_idx,
    input  wire logic [CFG_DW-1:0]    i_cfg_wdata,
    // input items
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [CMDW-1:0]      i_cmd,
    input  wire logic [ADW-1:0]       i_byte_addr,
    input  wire logic [BW-1:0]        i_byte_value,
    input  wire logic signed [QW-1:0] i_query_from,
    input  wire logic signed [QW-1:0] i_query_to,
    // result items
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [OW-1:0]             o_begin_byte,
    output logic [OW-1:0]             o_end_byte,
    output logic [OW-1:0]             o_codepoints
);

    localparam int unsigned CW = $clog2(MAX_BYTES + 1);
    localparam int unsigned AW = $clog2(MAX_BYTES);
    localparam int unsigned LW = (CW > CFG_DW) ? CW : CFG_DW;

    logic [CFG_DW-1:0]    r_text_length;
    logic                 r_ascii_only;
    logic signed [QW-1:0] r_query_from;
    logic signed [QW-1:0] r_query_to;
    logic                 r_out_valid;
    logic [OW-1:0]        r_begin_byte;
    logic [OW-1:0]        r_end_byte;
    logic [OW-1:0]        r_codepoints;

    logic                 w_in_accept;
    logic                 w_load;
    logic                 w_clr;
    logic [LW-1:0]        w_tl_k;
    logic [CW-1:0]        w_len;
    logic [AW+ADW-1:0]    w_waddr_ext;
    logic [AW-1:0]        w_raddr;
    logic [BW-1:0]        w_rdata;
    logic                 w_out_busy;
    logic                 w_out_load;
    logic [OW-1:0]        w_begin;
    logic [OW-1:0]        w_end;
    logic [OW-1:0]        w_count;
    t_walk_ctl            w_ctl;
    t_walk_sts            w_sts;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_load      = w_in_accept && (i_cmd == CMD_LOAD)
                         && (32'(i_byte_addr) < 32'(MAX_BYTES));
    assign w_clr       = i_cfg_we || (w_in_accept && (i_cmd == CMD_LOAD));
    assign w_waddr_ext = (AW + ADW)'(i_byte_addr);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_length <= '0;
            r_ascii_only  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEXT_LENGTH: r_text_length <= i_cfg_wdata;
                REG_ASCII_ONLY:  r_ascii_only  <= i_cfg_wdata[0];
                default:         r_ascii_only  <= r_ascii_only;
            endcase
        end
    end

    // string length in use, capped at the store depth
    assign w_tl_k = LW'(r_text_length);
    assign w_len  = (w_tl_k > LW'(MAX_BYTES)) ? CW'(MAX_BYTES) : w_tl_k[CW-1:0];

    // query positions held for both walks
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_query_from <= i_query_from;
            r_query_to   <= i_query_to;
        end
    end

    uci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_ascii    (r_ascii_only),
        .i_out_busy (w_out_busy),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_ctl      (w_ctl),
        .o_out_load (w_out_load)
    );

    uci_walk #(
        .MAX_BYTES (MAX_BYTES)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_clr   (w_clr),
        .i_ascii (r_ascii_only),
        .i_len   (w_len),
        .i_from  (r_query_from),
        .i_to    (r_query_to),
        .i_rdata (w_rdata),
        .o_sts   (w_sts),
        .o_raddr (w_raddr),
        .o_begin (w_begin),
        .o_end   (w_end),
        .o_count (w_count)
    );

    uci_store #(
        .MAX_BYTES (MAX_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_waddr_ext[AW-1:0]),
        .i_wdata (i_byte_value),
        .i_re    (w_ctl.rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // output register
    assign w_out_busy = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_begin_byte <= w_begin;
            r_end_byte   <= w_end;
            r_codepoints <= w_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_begin_byte = r_begin_byte;
    assign o_end_byte   = r_end_byte;
    assign o_codepoints = r_codepoints;

endmodule
`default_nettype wire

/* verif/uci_range_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uci_range_checker
// Watches the configuration port and both item channels of the codepoint
// range indexer, keeps its own copy of the byte store and registers, works
// out the byte range or codepoint count each query should return and
// compares every result item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module uci_range_checker
    import uci_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IW-1:0]    i_cfg_idx,
    input  wire logic [CFG_DW-1:0]    i_cfg_wdata,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [CMDW-1:0]      i_cmd,
    input  wire logic [ADW-1:0]       i_byte_addr,
    input  wire logic [BW-1:0]        i_byte_value,
    input  wire logic signed [QW-1:0] i_query_from,
    input  wire logic signed [QW-1:0] i_query_to,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [OW-1:0]        i_begin_byte,
    input  wire logic [OW-1:0]        i_end_byte,
    input  wire logic [OW-1:0]        i_codepoints,
    output int                        o_fail_count,
    output int                        o_pending
);

    typedef struct packed {
        logic [OW-1:0] begin_byte;
        logic [OW-1:0] end_byte;
        logic [OW-1:0] codepoints;
    } t_span;

    // shadow store and registers; the cursors only shorten walks, so they
    // have no part in what a query returns and are not kept here
    logic [BW-1:0]     text_mem [UCI_MAX_BYTES];
    logic [CFG_DW-1:0] text_len_reg;
    logic              ascii_mode;
    t_span             awaited_spans [$];
    int                mismatches;

    function automatic int unsigned string_len();
        return (text_len_reg > UCI_MAX_BYTES) ? UCI_MAX_BYTES : int'(text_len_reg);
    endfunction

    function automatic bit is_trail(input int unsigned b);
        return (b < UCI_MAX_BYTES) && (text_mem[b][7:6] == 2'b10);
    endfunction

    // one codepoint forward: one byte, then over continuation bytes
    function automatic int unsigned step_ahead(input int unsigned b, input int unsigned len);
        int unsigned p;
        p = b + 1;
        while (p < len && is_trail(p))
            p++;
        return p;
    endfunction

    // one codepoint back: one byte, then back over continuation bytes
    function automatic int unsigned step_behind(input int unsigned b);
        int unsigned p;
        p = b - 1;
        while (p > 0 && is_trail(p))
            p--;
        return p;
    endfunction

    // byte offset after pos codepoints from the start
    function automatic int unsigned offset_ahead(input int pos);
        int unsigned len;
        int unsigned c;
        int unsigned b;
        len = string_len();
        c = 0;
        b = 0;
        if (pos <= 0)
            return 0;
        if (ascii_mode)
            return (pos < len) ? pos : len;
        while (c < pos && b < len) begin
            b = step_ahead(b, len);
            c++;
        end
        return b;
    endfunction

    // byte offset pos codepoints before the end
    function automatic int unsigned offset_behind(input int pos);
        int unsigned len;
        int unsigned c;
        int unsigned b;
        len = string_len();
        c = 0;
        b = len;
        if (pos <= 0)
            return len;
        if (ascii_mode)
            return (len > pos) ? len - pos : 0;
        while (c < pos && b > 0) begin
            b = step_behind(b);
            c++;
        end
        return b;
    endfunction

    function automatic t_span byte_span_of(input logic signed [QW-1:0] from_pos,
                                           input logic signed [QW-1:0] to_pos);
        t_span r;
        int    f;
        int    t;
        f = from_pos;
        t = to_pos;
        r.begin_byte = OW'((f >= 0) ? offset_ahead((f > 0) ? f - 1 : 0) : offset_behind(-f));
        r.end_byte   = OW'((t >= 0) ? offset_ahead(t) : offset_behind(-t - 1));
        r.codepoints = '0;
        return r;
    endfunction

    function automatic t_span codepoint_total();
        t_span       r;
        int unsigned len;
        int unsigned n;
        int unsigned b;
        len = string_len();
        n = 0;
        b = 0;
        if (ascii_mode)
            n = len;
        else begin
            while (b < len) begin
                b = step_ahead(b, len);
                n++;
            end
        end
        r.begin_byte = '0;
        r.end_byte   = '0;
        r.codepoints = OW'(n);
        return r;
    endfunction

    // follow registers and store, queue predictions, compare result items
    always @(posedge i_clk) begin
        t_span seen;
        t_span want;
        if (!i_rst_n) begin
            for (int a = 0; a < UCI_MAX_BYTES; a++)
                text_mem[a] = '0;
            text_len_reg = '0;
            ascii_mode   = 1'b1;
            awaited_spans.delete();
            mismatches   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TEXT_LENGTH: text_len_reg = i_cfg_wdata;
                    REG_ASCII_ONLY:  ascii_mode   = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_begin_byte, i_end_byte, i_codepoints};
                if (awaited_spans.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result item with none awaited: begin %0d end %0d count %0d",
                                 $realtime, seen.begin_byte, seen.end_byte, seen.codepoints);
                end else begin
                    want = awaited_spans.pop_front();
                    if (seen.begin_byte !== want.begin_byte || seen.end_byte !== want.end_byte
                        || seen.codepoints !== want.codepoints) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected begin %0d end %0d count %0d, got %0d %0d %0d",
                                     $realtime, want.begin_byte, want.end_byte, want.codepoints,
                                     seen.begin_byte, seen.end_byte, seen.codepoints);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_cmd)
                    CMD_LOAD:  text_mem[i_byte_addr] = i_byte_value;
                    CMD_RANGE: awaited_spans.push_back(byte_span_of(i_query_from, i_query_to));
                    CMD_COUNT: awaited_spans.push_back(codepoint_total());
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_spans.size();
    end

endmodule

/* verif/utf8_codepoint_range_indexer_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_codepoint_range_indexer_core_test
// Drives load, range and count items into the indexer through phases of
// register settings and handshake idling, with a long result hold-off to
// back the block up; the checker beside the block predicts and compares,
// and this top gives the verdict.
// ----------------------------------------------------------------------------
module utf8_codepoint_range_indexer_core_test;
    import uci_pkg::*;

    localparam logic [CMDW-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 200000;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IW-1:0]     i_cfg_idx    = '0;
    logic [CFG_DW-1:0]     i_cfg_wdata  = '0;
    logic                  i_in_valid   = 1'b0;
    logic [CMDW-1:0]       i_cmd        = '0;
    logic [ADW-1:0]        i_byte_addr  = '0;
    logic [BW-1:0]         i_byte_value = '0;
    logic signed [QW-1:0]  i_query_from = '0;
    logic signed [QW-1:0]  i_query_to   = '0;
    logic                  i_out_stall  = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [OW-1:0]         o_begin_byte;
    logic [OW-1:0]         o_end_byte;
    logic [OW-1:0]         o_codepoints;

    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_pending    = 1'b0;
    int quiet_cycles;

    // short string with codepoints of every width from one to four bytes
    logic [BW-1:0] demo_text [11] = '{8'h41, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
                                      8'hF0, 8'h9F, 8'h98, 8'h80, 8'h7F};

    utf8_codepoint_range_indexer_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_byte_addr  (i_byte_addr),
        .i_byte_value (i_byte_value),
        .i_query_from (i_query_from),
        .i_query_to   (i_query_to),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_begin_byte (o_begin_byte),
        .o_end_byte   (o_end_byte),
        .o_codepoints (o_codepoints)
    );

    uci_range_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_byte_addr  (i_byte_addr),
        .i_byte_value (i_byte_value),
        .i_query_from (i_query_from),
        .i_query_to   (i_query_to),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_begin_byte (o_begin_byte),
        .i_end_byte   (o_end_byte),
        .i_codepoints (o_codepoints),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: random stall, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: ends the run when no item moves for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offer one item, with an optional gap before it, until it is taken
    task automatic send_item(input logic [CMDW-1:0] cmd, input logic [ADW-1:0] addr,
                             input logic [BW-1:0] val, input logic signed [QW-1:0] from_pos,
                             input logic signed [QW-1:0] to_pos);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_byte_addr  <= addr;
        i_byte_value <= val;
        i_query_from <= from_pos;
        i_query_to   <= to_pos;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic send_load(input logic [ADW-1:0] addr, input logic [BW-1:0] val);
        send_item(CMD_LOAD, addr, val, QW'($urandom), QW'($urandom));
    endtask

    task automatic send_range(input logic signed [QW-1:0] from_pos,
                              input logic signed [QW-1:0] to_pos);
        send_item(CMD_RANGE, ADW'($urandom), BW'($urandom), from_pos, to_pos);
    endtask

    task automatic send_count();
        send_item(CMD_COUNT, ADW'($urandom), BW'($urandom), QW'($urandom), QW'($urandom));
    endtask

    // stop offering, wait for every result, then let a load or unused item finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DW-1:0] len, input logic ascii);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_TEXT_LENGTH;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_idx   <= REG_ASCII_ONLY;
        i_cfg_wdata <= CFG_DW'(ascii);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // write nbytes of utf-8 lead and continuation bytes with random codepoint widths
    task automatic load_utf8_text(input int unsigned nbytes);
        int unsigned at;
        int unsigned width;
        at = 0;
        while (at < nbytes) begin
            width = $urandom_range(4, 1);
            if (width > nbytes - at)
                width = nbytes - at;
            case (width)
                1:       send_load(ADW'(at), BW'($urandom_range(8'h7F)));
                2:       send_load(ADW'(at), BW'($urandom_range(8'hDF, 8'hC2)));
                3:       send_load(ADW'(at), BW'($urandom_range(8'hEF, 8'hE0)));
                default: send_load(ADW'(at), BW'($urandom_range(8'hF4, 8'hF0)));
            endcase
            for (int t = 1; t < width; t++)
                send_load(ADW'(at + t), BW'($urandom_range(8'hBF, 8'h80)));
            at += width;
        end
    endtask

    // mostly near the string, sometimes the field extremes or anything
    function automatic logic signed [QW-1:0] pick_position(input int span);
        int roll;
        int pos;
        roll = $urandom_range(99);
        if (roll < 6)
            pos = -32768;
        else if (roll < 12)
            pos = 32767;
        else if (roll < 22)
            pos = $urandom_range(65535) - 32768;
        else
            pos = $urandom_range(2 * span) - span;
        return QW'(pos);
    endfunction

    task automatic run_random_phase(input logic [CFG_DW-1:0] len, input logic ascii,
                                    input int items, input int send_pct, input int recv_pct,
                                    input bit squeeze);
        int unsigned strlen;
        int          span;
        int          pick;
        strlen = (len > UCI_MAX_BYTES) ? UCI_MAX_BYTES : int'(len);
        span   = (ascii || strlen <= 64) ? strlen + 3 : 40;
        settle();
        set_config(len, ascii);
        sender_idle_pct = send_pct;
        recv_stall_pct  = recv_pct;
        if (!ascii)
            load_utf8_text(strlen);
        for (int k = 0; k < items; k++) begin
            if (squeeze && k == items / 2)
                hold_pending = 1'b1;
            // fresh text half way, the noise loads have broken the first one
            if (!ascii && strlen <= 64 && k == items / 2)
                load_utf8_text(strlen);
            pick = $urandom_range(99);
            if (pick < 55)
                send_range(pick_position(span), pick_position(span));
            else if (pick < 70)
                send_count();
            else if (pick < 85 && strlen > 0)
                send_load(ADW'($urandom_range(strlen - 1)), BW'($urandom_range(255)));
            else if (pick < 95)
                send_load(ADW'($urandom_range(UCI_MAX_BYTES - 1)), BW'($urandom_range(255)));
            else
                send_item(CMD_UNUSED, ADW'($urandom), BW'($urandom), QW'($urandom), QW'($urandom));
        end
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
    endtask

    // stimulus and verdict
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty string in ascii mode, as after reset
        send_count();
        send_range(16'sd0, 16'sd0);
        send_range(-16'sd32768, 16'sd32767);
        send_item(CMD_UNUSED, '1, '1, '1, '1);

        // codepoints of every width from one to four bytes
        settle();
        set_config(CFG_DW'(11), 1'b0);
        foreach (demo_text[i])
            send_load(ADW'(i), demo_text[i]);
        send_count();
        send_range(16'sd1, -16'sd1);
        send_range(16'sd2, 16'sd3);
        send_range(-16'sd2, -16'sd1);
        send_range(16'sd5, 16'sd2);                // reversed range
        send_range(16'sd0, 16'sd0);
        send_range(16'sd32767, -16'sd32768);
        // top of the store, outside the string
        send_load(12'hFFF, 8'hFF);
        // stray continuation bytes at the start make the text malformed
        send_load(12'd0, 8'hBF);
        send_load(12'd1, 8'h80);
        send_count();
        send_range(16'sd1, -16'sd1);

        run_random_phase(CFG_DW'(37),   1'b0, 60, 0,  0,  1'b1);
        run_random_phase(CFG_DW'(23),   1'b0, 60, 70, 0,  1'b0);
        run_random_phase(CFG_DW'(60),   1'b0, 60, 0,  70, 1'b0);
        run_random_phase(CFG_DW'(31),   1'b0, 60, 31, 31, 1'b0);
        run_random_phase(CFG_DW'(8191), 1'b1, 60, 31, 31, 1'b0);
        run_random_phase(CFG_DW'(4096), 1'b1, 40, 0,  70, 1'b0);
        run_random_phase(CFG_DW'(0),    1'b0, 30, 70, 0,  1'b0);
        run_random_phase(CFG_DW'(128),  1'b0, 20, 0,  0,  1'b0);
        run_random_phase(CFG_DW'(1),    1'b0, 30, 31, 31, 1'b0);
        run_random_phase(CFG_DW'(48),   1'b1, 80, 0,  0,  1'b1);

        settle();
        repeat (24) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
